// ===== rtl/core/kbs_pkg.sv =====
// Shared types, constants and the key-code table of the 4x4 keypad scanner.
package kbs_pkg;

  localparam int unsigned TimerWidthDefault = 16;
  localparam int unsigned CfgAddrWidth      = 2;
  localparam int unsigned CfgDataWidth      = 16;
  localparam int unsigned SettleWidth       = 16;
  localparam int unsigned LockoutCfgWidth   = 16;

  localparam logic [SettleWidth-1:0]     SettleTicksReset  = 16'd30;
  localparam logic [LockoutCfgWidth-1:0] LockoutTicksReset = 16'd100;

  localparam logic [CfgAddrWidth-1:0] CfgScanMode     = 2'd0;
  localparam logic [CfgAddrWidth-1:0] CfgSettleTicks  = 2'd1;
  localparam logic [CfgAddrWidth-1:0] CfgLockoutTicks = 2'd2;

  typedef struct packed {
    logic [3:0] row_levels;
    logic [3:0] row_rise;
  } kbs_in_t;

  typedef struct packed {
    logic [3:0]  column_drive;
    logic [15:0] key_map;
    logic        scan_busy;
  } kbs_out_t;

  // Key code for column col and row row.
  function automatic logic [3:0] key_code(input logic [1:0] col, input logic [1:0] row);
    logic [3:0] code;
    case ({col, row})
      4'h0: code = 4'd1;
      4'h1: code = 4'd4;
      4'h2: code = 4'd7;
      4'h3: code = 4'd10;
      4'h4: code = 4'd2;
      4'h5: code = 4'd5;
      4'h6: code = 4'd8;
      4'h7: code = 4'd0;
      4'h8: code = 4'd3;
      4'h9: code = 4'd6;
      4'hA: code = 4'd9;
      4'hB: code = 4'd11;
      4'hC: code = 4'd12;
      4'hD: code = 4'd13;
      4'hE: code = 4'd14;
      4'hF: code = 4'd15;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/matrix_keypad_scanner_4x4.sv =====
// Top level of the 4x4 matrix keypad scanner: scan state, key map and result register.
// An accepted request's result is registered and shows at the output in the next cycle.
// Throughput: one request per cycle unless stalled; scan state updates in the accepting cycle.
// The input side stalls only while the result register is full and the output side stalls.
// Reset (rst_ni low, asynchronous) clears the key map, counters and scan state, empties the
// result register, and loads scan_mode 0, settle_ticks 30 and lockout_ticks 100.
module matrix_keypad_scanner_4x4
  import kbs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  kbs_in_t                 in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output kbs_out_t                out_req_o
);

  // Width used to compare the lockout counter against the 16-bit threshold.
  localparam int unsigned CmpWidth =
    (TIMER_WIDTH > LockoutCfgWidth) ? TIMER_WIDTH : LockoutCfgWidth;
  localparam logic [TIMER_WIDTH-1:0] LockoutMax = {TIMER_WIDTH{1'b1}};

  // Configuration registers.
  logic                       scan_mode_q;
  logic [SettleWidth-1:0]     settle_ticks_q;
  logic [LockoutCfgWidth-1:0] lockout_ticks_q;

  // Scan state.
  logic [15:0]            pressed_keys_q, pressed_keys_d;
  logic [1:0]             column_index_q, column_index_d;
  logic [SettleWidth-1:0] settle_count_q, settle_count_d;
  logic [TIMER_WIDTH-1:0] lockout_count_q, lockout_count_d;
  logic                   scan_active_q, scan_active_d;
  logic [1:0]             trigger_row_q, trigger_row_d;

  // Result register.
  logic     out_valid_q;
  kbs_out_t out_req_q, out_req_d;

  logic accept;
  logic settle_hit;
  logic [SettleWidth-1:0] settle_next;
  logic scan_start;
  logic [1:0] rise_row;

  // A new request enters whenever the result register is empty or is drained this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign settle_hit  = settle_count_q >= settle_ticks_q;
  assign settle_next = settle_hit ? '0 : settle_count_q + 1'b1;

  // The lowest set rising-edge flag selects the row that the scan will watch.
  always_comb begin
    if (in_req_i.row_rise[0]) begin
      rise_row = 2'd0;
    end else if (in_req_i.row_rise[1]) begin
      rise_row = 2'd1;
    end else if (in_req_i.row_rise[2]) begin
      rise_row = 2'd2;
    end else begin
      rise_row = 2'd3;
    end
  end

  // An edge is honored only once more than lockout_ticks ticks have passed since the last scan.
  assign scan_start = scan_mode_q && !scan_active_q && (in_req_i.row_rise != 4'd0) &&
                      (CmpWidth'(lockout_count_q) > CmpWidth'(lockout_ticks_q));

  always_comb begin
    pressed_keys_d  = pressed_keys_q;
    column_index_d  = column_index_q;
    settle_count_d  = settle_count_q;
    scan_active_d   = scan_active_q;
    trigger_row_d   = trigger_row_q;
    out_req_d.scan_busy    = scan_active_q;
    out_req_d.column_drive = 4'hF;

    if (!scan_mode_q) begin
      // Polling: one column low, sample active-low rows once the column has settled.
      out_req_d.scan_busy    = 1'b0;
      scan_active_d          = 1'b0;
      out_req_d.column_drive = ~(4'b0001 << column_index_q);
      settle_count_d         = settle_next;
      if (settle_hit) begin
        for (int r = 0; r < 4; r++) begin
          pressed_keys_d[key_code(column_index_q, 2'(r))] = ~in_req_i.row_levels[r];
        end
        column_index_d = column_index_q + 1'b1;
      end
    end else if (scan_active_q) begin
      // Edge scan: one column high at a time, press-only update of the trigger row.
      out_req_d.column_drive = 4'b0001 << column_index_q;
      settle_count_d         = settle_next;
      if (settle_hit) begin
        if (in_req_i.row_levels[trigger_row_q]) begin
          pressed_keys_d[key_code(column_index_q, trigger_row_q)] = 1'b1;
        end
        if (column_index_q == 2'd3) begin
          scan_active_d = 1'b0;
        end
        column_index_d = column_index_q + 1'b1;
      end
    end else if (scan_start) begin
      // The accepting tick still drives all columns high; column 0 follows next tick.
      trigger_row_d  = rise_row;
      scan_active_d  = 1'b1;
      column_index_d = 2'd0;
      settle_count_d = '0;
    end

    if (scan_start) begin
      lockout_count_d = '0;
    end else if (lockout_count_q != LockoutMax) begin
      lockout_count_d = lockout_count_q + 1'b1;
    end else begin
      lockout_count_d = lockout_count_q;
    end

    out_req_d.key_map = pressed_keys_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q     <= 1'b0;
      settle_ticks_q  <= SettleTicksReset;
      lockout_ticks_q <= LockoutTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgScanMode:     scan_mode_q     <= cfg_wdata_i[0];
        CfgSettleTicks:  settle_ticks_q  <= cfg_wdata_i[SettleWidth-1:0];
        CfgLockoutTicks: lockout_ticks_q <= cfg_wdata_i[LockoutCfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_keys_q  <= '0;
      column_index_q  <= '0;
      settle_count_q  <= '0;
      lockout_count_q <= '0;
      scan_active_q   <= 1'b0;
      trigger_row_q   <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (accept) begin
        pressed_keys_q  <= pressed_keys_d;
        column_index_q  <= column_index_d;
        settle_count_q  <= settle_count_d;
        lockout_count_q <= lockout_count_d;
        scan_active_q   <= scan_active_d;
        trigger_row_q   <= trigger_row_d;
        out_valid_q     <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is loaded with every accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_req_q <= out_req_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

// ===== rtl/core/kbs_checker.sv =====
// Port-level checker of the 4x4 keypad scanner and its bind to the top level.
module kbs_checker
  import kbs_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic [CfgAddrWidth-1:0] cfg_addr_i,
  input logic [CfgDataWidth-1:0] cfg_wdata_i,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input kbs_in_t                 in_req_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input kbs_out_t                out_req_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // Every accepted request yields a result in the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no result");

  // The input side stalls only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // During an edge scan exactly one column is driven high.
  a_busy_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.scan_busy |-> $onehot(out_req_o.column_drive))
    else $error("scan result without a single driven column");

endmodule

bind matrix_keypad_scanner_4x4 kbs_checker u_kbs_checker (.*);
